// ----- hdl/pip_pkg.sv -----
package pip_pkg;

  localparam int DEFAULT_MAX_VERTICES = 256;
  localparam int COORD_W              = 32;
  localparam int TOL_W                = 16;
  localparam int OUT_CNT_W            = 9;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                      op;
    logic                      restart;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic                 inside_res;
    logic [OUT_CNT_W-1:0] crossing_count;
    logic [OUT_CNT_W-1:0] polygon_size;
    logic                 overflowed;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_LD0,
    S_NEXT,
    S_WAIT,
    S_MUL,
    S_DIV,
    S_ADD,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic append;
    logic q_load;
    logic rd;
    logic ld_first;
    logic setup;
    logic sel_first;
    logic mul;
    logic div_step;
    logic add;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic idx_end;
    logic straddle;
    logic div_done;
    logic last_edge;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/pip_ctrl.sv -----
module pip_ctrl
  import pip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          state_nxt = sts.cnt_zero ? S_DONE : S_RD0;
        end
      end
      S_RD0: state_nxt = S_LD0;
      S_LD0: state_nxt = S_NEXT;
      S_NEXT: state_nxt = sts.idx_end ? S_MUL : S_WAIT;
      S_WAIT: state_nxt = S_MUL;
      S_MUL: state_nxt = sts.straddle ? S_DIV : S_CMP;
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: state_nxt = S_CMP;
      S_CMP: state_nxt = sts.last_edge ? S_DONE : S_NEXT;
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.append = accept && (in_op == OP_APPEND);
        cmd.q_load = accept && (in_op == OP_QUERY);
      end
      S_RD0: cmd.rd = 1'b1;
      S_LD0: cmd.ld_first = 1'b1;
      S_NEXT: begin
        if (sts.idx_end) begin
          cmd.setup     = 1'b1;
          cmd.sel_first = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_WAIT: cmd.setup = 1'b1;
      S_MUL: cmd.mul = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_ADD: cmd.add = 1'b1;
      S_CMP: cmd.cmp = 1'b1;
      S_DONE: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/pip_dp.sv -----
module pip_dp
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = 2 * COORD_W;

  logic [DW-1:0] mem [MAX_VERTICES];
  logic [DW-1:0] rdata_r;

  logic [TOL_W-1:0] tol_r;
  logic [CW-1:0]    cnt_r, idx_r, cross_cnt_r;
  logic             ovf_r, last_r, straddle_r, neg_r, out_valid_r;
  logic [4:0]       div_cnt_r;
  logic signed [COORD_W-1:0] qx_r, qy_r, fx_r, fy_r, px_r, py_r, x1_r;
  logic [COORD_W-1:0] amag_r, bmag_r, dmag_r, rem_r, lo_r;
  logic signed [COORD_W+1:0] cross_r;
  out_word_t out_r;

  logic                 store_ok;
  logic [AW-1:0]        waddr;
  logic signed [COORD_W-1:0] ex, ey;
  logic signed [COORD_W:0]   a_s, b_s, d_s;
  logic [COORD_W:0]          trial;
  logic                      take;
  logic signed [COORD_W+2:0] diff;
  logic                      hit;

  assign store_ok = in_word.restart || (cnt_r < CW'(MAX_VERTICES));
  assign waddr    = in_word.restart ? '0 : cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.append && store_ok) begin
      mem[waddr] <= {in_word.coord_x, in_word.coord_y};
    end
    if (cmd.rd) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign ex  = cmd.sel_first ? fx_r : $signed(rdata_r[DW-1:COORD_W]);
  assign ey  = cmd.sel_first ? fy_r : $signed(rdata_r[COORD_W-1:0]);
  assign a_s = {qy_r[COORD_W-1], qy_r} - {py_r[COORD_W-1], py_r};
  assign b_s = {ex[COORD_W-1], ex} - {px_r[COORD_W-1], px_r};
  assign d_s = {ey[COORD_W-1], ey} - {py_r[COORD_W-1], py_r};

  assign trial = {rem_r, lo_r[COORD_W-1]};
  assign take  = trial >= {1'b0, dmag_r};

  assign diff = {qx_r[COORD_W-1], qx_r[COORD_W-1], qx_r[COORD_W-1], qx_r}
              - {cross_r[COORD_W+1], cross_r};
  assign hit  = (diff < 0) || (diff < $signed({{(COORD_W+3-TOL_W){1'b0}}, tol_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (cmd.append) begin
        if (in_word.restart) begin
          cnt_r <= CW'(1);
          ovf_r <= 1'b0;
        end else if (store_ok) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      qx_r        <= in_word.coord_x;
      qy_r        <= in_word.coord_y;
      idx_r       <= '0;
      cross_cnt_r <= '0;
      last_r      <= 1'b0;
    end
    if (cmd.rd) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.ld_first) begin
      fx_r <= $signed(rdata_r[DW-1:COORD_W]);
      fy_r <= $signed(rdata_r[COORD_W-1:0]);
      px_r <= $signed(rdata_r[DW-1:COORD_W]);
      py_r <= $signed(rdata_r[COORD_W-1:0]);
    end
    if (cmd.setup) begin
      straddle_r <= (py_r > qy_r) != (ey > qy_r);
      amag_r     <= COORD_W'(a_s[COORD_W] ? -a_s : a_s);
      bmag_r     <= COORD_W'(b_s[COORD_W] ? -b_s : b_s);
      dmag_r     <= COORD_W'(d_s[COORD_W] ? -d_s : d_s);
      neg_r      <= a_s[COORD_W] ^ b_s[COORD_W] ^ d_s[COORD_W];
      x1_r       <= px_r;
      px_r       <= ex;
      py_r       <= ey;
      last_r     <= cmd.sel_first;
    end
    if (cmd.mul) begin
      {rem_r, lo_r} <= amag_r * bmag_r;
      div_cnt_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= take ? COORD_W'(trial - {1'b0, dmag_r}) : trial[COORD_W-1:0];
      lo_r      <= {lo_r[COORD_W-2:0], take};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.add) begin
      cross_r <= {{2{x1_r[COORD_W-1]}}, x1_r}
               + (neg_r ? -$signed({2'b00, lo_r}) : $signed({2'b00, lo_r}));
    end
    if (cmd.cmp && straddle_r && hit) begin
      cross_cnt_r <= cross_cnt_r + CW'(1);
    end
    if (cmd.out_load) begin
      out_r.inside_res     <= cross_cnt_r[0];
      out_r.crossing_count <= OUT_CNT_W'(cross_cnt_r);
      out_r.polygon_size   <= OUT_CNT_W'(cnt_r);
      out_r.overflowed     <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    sts.cnt_zero  = (cnt_r == '0);
    sts.idx_end   = (idx_r == cnt_r);
    sts.straddle  = straddle_r;
    sts.div_done  = (div_cnt_r == 5'd31);
    sts.last_edge = last_r;
    sts.out_busy  = out_valid_r && out_stall;
  end

endmodule

// ----- hdl/point_in_polygon_test.sv -----
// Word        | Ports                                 | Accepted when
// config      | cfg_we, cfg_wdata                     | cfg_we high
// input       | in_valid, in_stall, in_word           | in_valid high, in_stall low
// result      | out_valid, out_stall, out_word        | out_valid high, out_stall low
// A query on an empty store goes straight to the result; otherwise the first vertex
// is read and loaded; each edge is then fetched, set up and multiplied, and one
// that straddles the query y also passes the 32-step shift-subtract divider and an
// add before its crossing compare. A query also waits while an earlier result is
// still held by out_stall. Reset clears the vertex count, the overflow flag and the
// tolerance (to one); the vertex memory is not cleared.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  cmd_t cmd;
  sts_t sts;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
